// ----- design/interrupt_drain_budget_policy_defines.svh -----
// ----------------------------------------------------------------------------
// Interrupt drain budget policy: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_DRAIN_BUDGET_POLICY_DEFINES_SVH
`define INTERRUPT_DRAIN_BUDGET_POLICY_DEFINES_SVH

// Same-cycle implication
`define IDBP_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication
`define IDBP_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- design/idbp_pkg.sv -----
// ----------------------------------------------------------------------------
// idbp_pkg
// Types, codes and helpers for the interrupt drain budget policy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package idbp_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int CMP_BITS   = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
    localparam int CFG_ADDR_BITS = 3;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CFG_BITS-1:0]   limit_t;
    typedef logic [1:0]            kind_t;
    typedef logic [1:0]            status_t;
    typedef logic [3:0]            action_t;

    localparam kind_t KIND_START      = 2'd0;
    localparam kind_t KIND_PRE_POLL   = 2'd1;
    localparam kind_t KIND_POST_POLL  = 2'd2;
    localparam kind_t KIND_NONE       = 2'd3;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_TIMEOUT    = 2'd1;
    localparam status_t ST_ALL_ZERO   = 2'd2;
    localparam status_t ST_XPORT_ERR  = 2'd3;

    localparam action_t ACT_CONTINUE  = 4'd0;
    localparam action_t ACT_COMPLETE  = 4'd1;
    localparam action_t ACT_ITER_CAP  = 4'd2;
    localparam action_t ACT_ZERO_BUDG = 4'd3;
    localparam action_t ACT_NOPR_BUDG = 4'd4;
    localparam action_t ACT_XPORT_ERR = 4'd5;
    localparam action_t ACT_PKT_CAP   = 4'd6;
    localparam action_t ACT_FLUSH_BUD = 4'd7;
    localparam action_t ACT_EVT_BUDG  = 4'd8;

    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_POLL   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_ZERO   = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_NOPROG = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_PKT    = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_FLUSH  = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_EVT    = 3'd5;

    localparam limit_t RST_MAX_POLL   = 16'd64;
    localparam limit_t RST_MAX_ZERO   = 16'd4;
    localparam limit_t RST_MAX_NOPROG = 16'd8;
    localparam limit_t RST_MAX_PKT    = 16'd32;
    localparam limit_t RST_MAX_FLUSH  = 16'd16;
    localparam limit_t RST_MAX_EVT    = 16'd32;

    typedef struct packed {
        kind_t   kind;
        logic    hint;
        status_t status;
        logic    pkt;
        logic    evt;
        logic    pend;
        logic    ctl;
    } item_t;

    typedef struct packed {
        action_t action;
        logic    hint_echo;
        logic    made_progress;
    } result_t;

    typedef struct packed {
        limit_t max_poll;
        limit_t max_zero;
        limit_t max_noprog;
        limit_t max_pkt;
        limit_t max_flush;
        limit_t max_evt;
    } cfg_t;

    function automatic count_t sat_inc(input count_t v);
        sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + count_t'(1);
    endfunction

    function automatic logic reached(input count_t cnt, input limit_t lim);
        reached = CMP_BITS'(cnt) >= CMP_BITS'(lim);
    endfunction

endpackage

// ----- design/idbp_core.sv -----
// ----------------------------------------------------------------------------
// idbp_core
// Drain counters and prioritized action decode for one transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "interrupt_drain_budget_policy_defines.svh"

module idbp_core
    import idbp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    count_t poll_reg,   poll_next;
    count_t noprog_reg, noprog_next;
    count_t zero_reg,   zero_next;
    count_t pkt_reg,    pkt_next;
    count_t evt_reg,    evt_next;
    count_t pend_reg,   pend_next;
    logic   ctl_reg,    ctl_next;
    action_t action;

    always_comb
    begin
        poll_next   = poll_reg;
        noprog_next = noprog_reg;
        zero_next   = zero_reg;
        pkt_next    = pkt_reg;
        evt_next    = evt_reg;
        pend_next   = pend_reg;
        ctl_next    = ctl_reg;
        action      = ACT_CONTINUE;
        unique case (item.kind)
            KIND_START:
            begin
                poll_next   = '0;
                noprog_next = '0;
                zero_next   = '0;
                pkt_next    = '0;
                evt_next    = '0;
                pend_next   = '0;
                ctl_next    = 1'b0;
            end
            KIND_PRE_POLL:
            begin
                if (reached(poll_reg, cfg.max_poll))
                    action = ACT_ITER_CAP;
            end
            KIND_POST_POLL:
            begin
                poll_next = sat_inc(poll_reg);
                if (item.status == ST_TIMEOUT || item.status == ST_ALL_ZERO)
                begin
                    noprog_next = sat_inc(noprog_reg);
                    zero_next   = (item.status == ST_ALL_ZERO) ? sat_inc(zero_reg) : '0;
                    priority if (!item.hint)
                        action = ACT_COMPLETE;
                    else if (item.status == ST_ALL_ZERO && reached(zero_next, cfg.max_zero))
                        action = ACT_ZERO_BUDG;
                    else if (reached(noprog_next, cfg.max_noprog))
                        action = ACT_NOPR_BUDG;
                    else
                        action = ACT_CONTINUE;
                end
                else
                begin
                    if (item.pkt)
                        pkt_next = sat_inc(pkt_reg);
                    if (item.evt)
                        evt_next = sat_inc(evt_reg);
                    if (item.pend)
                        pend_next = sat_inc(pend_reg);
                    if (item.ctl)
                        ctl_next = 1'b1;
                    if (item.pkt || item.evt || item.pend || item.ctl)
                    begin
                        noprog_next = '0;
                        zero_next   = '0;
                    end
                    priority if (item.status == ST_XPORT_ERR)
                        action = ACT_XPORT_ERR;
                    else if (reached(pkt_next, cfg.max_pkt))
                        action = ACT_PKT_CAP;
                    else if (item.pend && reached(pend_next, cfg.max_flush))
                        action = ACT_FLUSH_BUD;
                    else if (!item.pend && reached(evt_next, cfg.max_evt))
                        action = ACT_EVT_BUDG;
                    else
                        action = ACT_CONTINUE;
                end
            end
            default:
            begin
                action = ACT_CONTINUE;
            end
        endcase
    end

    always_comb
    begin
        result.action        = action;
        result.hint_echo     = item.hint;
        result.made_progress = (pkt_next != '0) || (evt_next != '0) || ctl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_reg   <= '0;
            noprog_reg <= '0;
            zero_reg   <= '0;
            pkt_reg    <= '0;
            evt_reg    <= '0;
            pend_reg   <= '0;
            ctl_reg    <= 1'b0;
        end
        else if (adv)
        begin
            poll_reg   <= poll_next;
            noprog_reg <= noprog_next;
            zero_reg   <= zero_next;
            pkt_reg    <= pkt_next;
            evt_reg    <= evt_next;
            pend_reg   <= pend_next;
            ctl_reg    <= ctl_next;
        end
    end

    `IDBP_ASSERT_NEXT(a_start_clears, adv && item.kind == KIND_START, poll_reg == '0 && noprog_reg == '0 && zero_reg == '0 && pkt_reg == '0 && evt_reg == '0 && pend_reg == '0 && !ctl_reg, "drain start left a counter set")
    `IDBP_ASSERT_NEXT(a_poll_monotonic, adv && item.kind != KIND_START, poll_reg >= $past(poll_reg), "poll count fell without drain start")
    `IDBP_ASSERT_NOW(a_complete_no_hint, adv && result.action == ACT_COMPLETE, !item.hint, "complete reported with hint asserted")
    `IDBP_ASSERT_NOW(a_start_no_progress, adv && item.kind == KIND_START, !result.made_progress && result.action == ACT_CONTINUE, "drain start reported progress or a stop")

endmodule

// ----- design/interrupt_drain_budget_policy.sv -----
// A transaction accepted into the input register shows its result on m_* once it has moved into the result register.
// Throughput: one transaction per cycle while m_tready does not stall; input register, policy logic, result register.
// The result register stalls on m_tready and backs up into the input register.
// Reset clears all drain counters and the valid flags of both pipeline stages.
// Reset loads the limit registers with their default values.
// ----------------------------------------------------------------------------
// interrupt_drain_budget_policy
// Budgets one interrupt drain of a sensor hub link and returns stop actions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interrupt_drain_budget_policy
    import idbp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // hint_asserted, poll_status[1:0],
                                                // phys_packet, produced_event,
                                                // dequeued_pending, handled_control, pad
    input  logic [1:0]               s_tuser,   // kind[1:0]
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,   // action[3:0], hint_echo, made_progress, pad
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_BITS-1:0]      cfg_data
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    cfg_t    cfg_reg;
    result_t result;
    item_t   s_item;
    logic    adv;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_comb
    begin
        s_item.kind   = s_tuser;
        s_item.hint   = s_tdata[0];
        s_item.status = s_tdata[2:1];
        s_item.pkt    = s_tdata[3];
        s_item.evt    = s_tdata[4];
        s_item.pend   = s_tdata[5];
        s_item.ctl    = s_tdata[6];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= s_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_poll   <= RST_MAX_POLL;
            cfg_reg.max_zero   <= RST_MAX_ZERO;
            cfg_reg.max_noprog <= RST_MAX_NOPROG;
            cfg_reg.max_pkt    <= RST_MAX_PKT;
            cfg_reg.max_flush  <= RST_MAX_FLUSH;
            cfg_reg.max_evt    <= RST_MAX_EVT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MAX_POLL:   cfg_reg.max_poll   <= cfg_data;
                REG_MAX_ZERO:   cfg_reg.max_zero   <= cfg_data;
                REG_MAX_NOPROG: cfg_reg.max_noprog <= cfg_data;
                REG_MAX_PKT:    cfg_reg.max_pkt    <= cfg_data;
                REG_MAX_FLUSH:  cfg_reg.max_flush  <= cfg_data;
                REG_MAX_EVT:    cfg_reg.max_evt    <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    idbp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg.made_progress, out_data_reg.hint_echo,
                       out_data_reg.action};

endmodule
